// ----- sv/scfl_pkg.sv -----
// Shared constants, codes, types and the size-class function for the free-list manager.
package scfl_pkg;

  // Pool geometry.
  localparam int CLASS_COUNT    = 8;
  localparam int SMALLEST_CLASS = 16;
  localparam int HDR_BYTES      = 16;
  localparam int SLOT_COUNT     = 256;

  // Derived widths: a slot index, a pointer that can also hold the empty marker, a class.
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int PTR_W  = $clog2(SLOT_COUNT + 1);
  localparam int CLS_W  = $clog2(CLASS_COUNT);
  localparam int SIZE_W = 21;
  localparam int REQ_W  = 20;

  // Empty-list marker held in a class head.
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOT_COUNT);

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_REUSED   = 2'd0;
  localparam logic [1:0] STAT_FRESH    = 2'd1;
  localparam logic [1:0] STAT_NO_SLOT  = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // A transaction is taken this cycle.
    logic execute;  // The taken transaction commits this cycle.
  } scfl_ctl_t;

  // Smallest class whose capacity holds the byte count, capped at the last class.
  // The thresholds rise with the class, so each compare is independent.
  function automatic logic [CLS_W-1:0] class_of(input logic [31:0] bytes);
    logic [CLS_W-1:0] cls;
    logic [63:0]      thr;
    cls = '0;
    for (int k = 0; k < CLASS_COUNT - 1; k++) begin
      thr = 64'(SMALLEST_CLASS) << k;
      if ({32'b0, bytes} > thr) begin
        cls = CLS_W'(k + 1);
      end
    end
    return cls;
  endfunction

endpackage

// ----- sv/scfl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module scfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/scfl_ctrl.sv -----
// Controller state machine: takes one transaction and sequences its commit.
module scfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output scfl_pkg::scfl_ctl_t ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Command decode.
  assign busy        = (state == ST_EXEC);
  assign ctl.load    = start && (state == ST_IDLE);
  assign ctl.execute = (state == ST_EXEC);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.execute;
    end
  end

`ifndef ASSERT_OFF
  // A commit lasts exactly one cycle and is followed by the result strobe.
  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |=> (!busy && done))
    else $error("commit not followed by result strobe");

  // A taken transaction always moves the machine to the commit cycle.
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> ctl.execute)
    else $error("taken transaction did not commit");

  // The strobe never appears without a commit just before it.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.execute))
    else $error("result strobe without commit");
`endif

endmodule

// ----- sv/scfl_dp.sv -----
// Datapath: class heads, fresh counter, link and size memories, result registers.
module scfl_dp (
  input  logic                clk,
  input  logic                rst,
  input  scfl_pkg::scfl_ctl_t ctl,
  input  logic                cmd,
  input  logic [19:0]         req_size,
  input  logic [7:0]          slot_id,
  output logic [1:0]          status,
  output logic [7:0]          granted_slot,
  output logic [2:0]          size_class
);

  // Architectural state kept in flip-flops.
  logic [scfl_pkg::PTR_W-1:0]  class_head [scfl_pkg::CLASS_COUNT];
  logic [scfl_pkg::PTR_W-1:0]  fresh_count;

  // Transaction registers.
  logic                          cmd_q;
  logic [scfl_pkg::REQ_W-1:0]    req_q;
  logic [scfl_pkg::SLOT_W-1:0]   sid_q;
  logic                          sid_in_pool_q;
  logic [scfl_pkg::CLS_W-1:0]    cls_q;
  logic [scfl_pkg::PTR_W-1:0]    head_q;

  // Input-side decode used in the cycle a transaction is taken.
  logic [scfl_pkg::CLS_W-1:0]    in_cls;
  logic [scfl_pkg::PTR_W-1:0]    in_head;

  // Memory ports. A size memory word holds the listed flag above the recorded size.
  logic                          link_we;
  logic [scfl_pkg::SLOT_W-1:0]   link_waddr;
  logic [scfl_pkg::PTR_W-1:0]    link_wdata;
  logic [scfl_pkg::PTR_W-1:0]    link_rdata;
  logic                          size_we;
  logic [scfl_pkg::SLOT_W-1:0]   size_waddr;
  logic [scfl_pkg::SIZE_W:0]     size_wdata;
  logic [scfl_pkg::SIZE_W:0]     size_rdata;
  logic                          slot_listed;
  logic [scfl_pkg::SIZE_W-1:0]   slot_size;

  // Commit decode.
  logic                          have_head;
  logic                          have_fresh;
  logic                          free_ok;
  logic [31:0]                   payload;
  logic [scfl_pkg::CLS_W-1:0]    free_cls;
  logic                          head_we;
  logic [scfl_pkg::CLS_W-1:0]    head_widx;
  logic [scfl_pkg::PTR_W-1:0]    head_wdata;
  logic                          fresh_inc;
  logic [1:0]                    res_status;
  logic [scfl_pkg::SLOT_W-1:0]   res_slot;
  logic [scfl_pkg::CLS_W-1:0]    res_cls;

  // Class of the incoming request and the head it would pop; both memories are read
  // from the input ports so their data is ready in the commit cycle.
  assign in_cls  = scfl_pkg::class_of(32'(req_size));
  assign in_head = class_head[in_cls];

  scfl_ram #(
    .WIDTH (scfl_pkg::PTR_W),
    .DEPTH (scfl_pkg::SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (in_head[scfl_pkg::SLOT_W-1:0]),
    .rdata (link_rdata)
  );

  scfl_ram #(
    .WIDTH (scfl_pkg::SIZE_W + 1),
    .DEPTH (scfl_pkg::SLOT_COUNT)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (scfl_pkg::SLOT_W'(slot_id)),
    .rdata (size_rdata)
  );

  // Fields of the slot word read for a free.
  assign slot_listed = size_rdata[scfl_pkg::SIZE_W];
  assign slot_size   = size_rdata[scfl_pkg::SIZE_W-1:0];

  // Capture the transaction.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q         <= cmd;
      req_q         <= req_size;
      sid_q         <= scfl_pkg::SLOT_W'(slot_id);
      sid_in_pool_q <= (32'(slot_id) < 32'(fresh_count));
      cls_q         <= in_cls;
      head_q        <= in_head;
    end
  end

  // Commit decode. Slots at or above the fresh count were never granted, so their
  // memory words are unwritten and a free of one of them is rejected together with
  // listed and unsized slots.
  always_comb begin
    have_head  = (head_q != scfl_pkg::NIL_PTR);
    have_fresh = (fresh_count != scfl_pkg::PTR_W'(scfl_pkg::SLOT_COUNT));
    free_ok    = sid_in_pool_q && !slot_listed && (slot_size != '0);
    payload    = (32'(slot_size) >= 32'(scfl_pkg::HDR_BYTES)) ?
                 (32'(slot_size) - 32'(scfl_pkg::HDR_BYTES)) : 32'd0;
    free_cls   = scfl_pkg::class_of(payload);

    head_we    = 1'b0;
    head_widx  = cls_q;
    head_wdata = link_rdata;
    link_we    = 1'b0;
    link_waddr = sid_q;
    link_wdata = class_head[free_cls];
    size_we    = 1'b0;
    size_waddr = head_q[scfl_pkg::SLOT_W-1:0];
    size_wdata = {1'b0, scfl_pkg::SIZE_W'(32'(req_q) + 32'(scfl_pkg::HDR_BYTES))};
    fresh_inc  = 1'b0;
    res_status = scfl_pkg::STAT_NO_SLOT;
    res_slot   = '0;
    res_cls    = cls_q;

    if (cmd_q == scfl_pkg::CMD_ALLOC) begin
      if (have_head) begin
        // Pop the class list; the new size word clears the listed flag.
        head_we    = 1'b1;
        size_we    = 1'b1;
        res_status = scfl_pkg::STAT_REUSED;
        res_slot   = head_q[scfl_pkg::SLOT_W-1:0];
      end else if (have_fresh) begin
        // Take a never-used slot.
        size_we    = 1'b1;
        size_waddr = fresh_count[scfl_pkg::SLOT_W-1:0];
        fresh_inc  = 1'b1;
        res_status = scfl_pkg::STAT_FRESH;
        res_slot   = fresh_count[scfl_pkg::SLOT_W-1:0];
      end
    end else begin
      res_slot = sid_q;
      if (free_ok) begin
        // Push the slot on the class of its payload size and mark it listed.
        head_we    = 1'b1;
        head_widx  = free_cls;
        head_wdata = scfl_pkg::PTR_W'(sid_q);
        size_we    = 1'b1;
        size_waddr = sid_q;
        size_wdata = {1'b1, slot_size};
        link_we    = 1'b1;
        res_status = scfl_pkg::STAT_REUSED;
        res_cls    = free_cls;
      end else begin
        res_status = scfl_pkg::STAT_BAD_FREE;
        res_cls    = '0;
      end
    end

    if (!ctl.execute) begin
      head_we   = 1'b0;
      link_we   = 1'b0;
      size_we   = 1'b0;
      fresh_inc = 1'b0;
    end
  end

  // Class heads and fresh counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scfl_pkg::CLASS_COUNT; i++) begin
        class_head[i] <= scfl_pkg::NIL_PTR;
      end
      fresh_count <= '0;
    end else begin
      if (head_we) begin
        class_head[head_widx] <= head_wdata;
      end
      if (fresh_inc) begin
        fresh_count <= fresh_count + 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status       <= res_status;
      granted_slot <= 8'(res_slot);
      size_class   <= 3'(res_cls);
    end
  end

`ifndef ASSERT_OFF
  // The fresh counter never runs past the pool.
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fresh_count) <= 32'(scfl_pkg::SLOT_COUNT))
    else $error("fresh counter beyond pool");

  // A fresh grant advances the counter by exactly one.
  a_fresh_step: assert property (@(posedge clk) disable iff (rst)
    fresh_inc |=> (fresh_count == $past(fresh_count) + 1'b1))
    else $error("fresh counter did not advance");

  // A successful free leaves the slot at the head of its class.
  a_push_head: assert property (@(posedge clk) disable iff (rst)
    (link_we && head_we) |=>
      (class_head[$past(free_cls)] == scfl_pkg::PTR_W'($past(sid_q))))
    else $error("freed slot not at list head");
`endif

endmodule

// ----- sv/size_class_free_list_manager.sv -----
// Top level of the size-class free-list manager: controller and datapath.
//
// Channel   Handshake                  Payload
// command   start in, busy out         cmd, req_size, slot_id
// result    done out (one-cycle pulse) status, granted_slot, size_class
//
// A transaction is taken at the edge where start is high and busy is low.
// Busy is high for the one commit cycle that follows; the result is on the ports
// with done in the cycle after that. The registered reads of the link and size
// memories, taken with the transaction, feed its commit cycle.
// A new transaction can be taken in the same cycle its predecessor's result shows.
// Reset (rst, synchronous) empties all class lists and the fresh counter at once.
// The receiver cannot stall: each result is taken in the cycle done is high.
module size_class_free_list_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [19:0] req_size,
  input  logic [7:0]  slot_id,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  granted_slot,
  output logic [2:0]  size_class
);

  scfl_pkg::scfl_ctl_t ctl;

  // Sequencing.
  scfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // Lists, memories and result registers.
  scfl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .req_size     (req_size),
    .slot_id      (slot_id),
    .status       (status),
    .granted_slot (granted_slot),
    .size_class   (size_class)
  );

endmodule
